### rtl/lgg_pkg.sv
`timescale 1ns / 1ps

package lgg_pkg;

  localparam int LGG_ROWS = 8;
  localparam int LGG_COLS = 16;

  localparam int KIND_W  = 2;
  localparam int ROW_W   = 3;
  localparam int COL_W   = 4;
  localparam int BITS_W  = 16;
  localparam int COUNT_W = 4;

  localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd2;

  localparam logic [COUNT_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [COUNT_W-1:0] SURVIVE_COUNT = 4'd2;
  localparam logic [COUNT_W-1:0] MAX_COUNT     = 4'd8;

endpackage

### rtl/lgg_cell.sv
`timescale 1ns / 1ps

// One grid row; takes its neighbor's row on every shift.
module lgg_cell #(
  parameter int GRID_COLS = lgg_pkg::LGG_COLS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 shift,
  input  logic [GRID_COLS-1:0] d,
  output logic [GRID_COLS-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

### rtl/lgg_rule.sv
`timescale 1ns / 1ps

// Next-generation row and per-column neighbor counts for the middle row.
module lgg_rule #(
  parameter int GRID_COLS = lgg_pkg::LGG_COLS,
  localparam int CW = $clog2(GRID_COLS)
) (
  input  logic [GRID_COLS-1:0]          above,
  input  logic [GRID_COLS-1:0]          mid,
  input  logic [GRID_COLS-1:0]          below,
  input  logic [CW-1:0]                 sel,
  output logic [GRID_COLS-1:0]          next_row,
  output logic [lgg_pkg::COUNT_W-1:0]   sel_count
);

  logic [GRID_COLS-1:0] above_l, above_r, mid_l, mid_r, below_l, below_r;
  logic [lgg_pkg::COUNT_W-1:0] counts [GRID_COLS];

  // _l: bit c holds column c+1, _r: bit c holds column c-1, both wrapped
  assign above_l = {above[0], above[GRID_COLS-1:1]};
  assign above_r = {above[GRID_COLS-2:0], above[GRID_COLS-1]};
  assign mid_l   = {mid[0], mid[GRID_COLS-1:1]};
  assign mid_r   = {mid[GRID_COLS-2:0], mid[GRID_COLS-1]};
  assign below_l = {below[0], below[GRID_COLS-1:1]};
  assign below_r = {below[GRID_COLS-2:0], below[GRID_COLS-1]};

  always_comb begin
    for (int c = 0; c < GRID_COLS; c++) begin
      counts[c] = lgg_pkg::COUNT_W'(above_l[c]) + lgg_pkg::COUNT_W'(above[c])
                + lgg_pkg::COUNT_W'(above_r[c]) + lgg_pkg::COUNT_W'(mid_l[c])
                + lgg_pkg::COUNT_W'(mid_r[c]) + lgg_pkg::COUNT_W'(below_l[c])
                + lgg_pkg::COUNT_W'(below[c]) + lgg_pkg::COUNT_W'(below_r[c]);
      next_row[c] = (counts[c] == lgg_pkg::BIRTH_COUNT)
                 || (mid[c] && (counts[c] == lgg_pkg::SURVIVE_COUNT));
    end
  end

  assign sel_count = counts[sel];

endmodule

### rtl/life_grid_generation.sv
`timescale 1ns / 1ps

// Toroidal Life grid, GRID_ROWS x GRID_COLS cells, one bit per cell.
// Input channel (in_valid/in_ready) carries one command item: kind 0 steps
// one generation, kind 1 sets cell (row, col) to alive, kind 2 queries a
// cell. kind 3 and out-of-range sets change nothing.
// Output channel (out_valid/out_ready) carries one item per query: the row's
// bits, the cell state and its wrapped live-neighbor count. An out-of-range
// query returns all zeros.
// The rows sit in a ring of row cells that rotates once per command, one row
// per clock past a single rule unit at the head unless the ring is stalled;
// in_ready drops while a command runs, so a new item is taken only after the
// previous command's revolution has finished.
// A new command is taken while a result still waits; if the previous result
// is still unread when a query finishes, the ring holds on its last step
// until out_ready.
// Reset (rst, synchronous) clears every cell and drops out_valid.
module life_grid_generation #(
  parameter int GRID_ROWS = lgg_pkg::LGG_ROWS,
  parameter int GRID_COLS = lgg_pkg::LGG_COLS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lgg_pkg::KIND_W-1:0]   kind,
  input  logic [lgg_pkg::ROW_W-1:0]    row,
  input  logic [lgg_pkg::COL_W-1:0]    col,
  input  logic                         alive,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lgg_pkg::BITS_W-1:0]   row_bits,
  output logic                         cell_alive,
  output logic [lgg_pkg::COUNT_W-1:0]  neighbor_count
);

  localparam int RW   = $clog2(GRID_ROWS);
  localparam int CW   = $clog2(GRID_COLS);
  localparam int CMPW = (RW > lgg_pkg::ROW_W) ? RW : lgg_pkg::ROW_W;

  logic [GRID_COLS-1:0] rows_q [GRID_ROWS];
  logic [GRID_COLS-1:0] head, head_new, above, below, prev_old, first_old;
  logic [GRID_COLS-1:0] rule_row, set_mask;
  logic [lgg_pkg::COUNT_W-1:0] rule_count;

  logic                        busy;
  logic [RW-1:0]               cnt;
  logic [lgg_pkg::KIND_W-1:0]  kind_q;
  logic [lgg_pkg::ROW_W-1:0]   row_q;
  logic [lgg_pkg::COL_W-1:0]   col_q;
  logic                        alive_q;

  logic [lgg_pkg::BITS_W-1:0]  hit_bits, hit_bits_next;
  logic                        hit_alive, hit_alive_next;
  logic [lgg_pkg::COUNT_W-1:0] hit_count, hit_count_next;

  logic last, stall, step, accept, row_hit, col_ok, is_query;

  assign head     = rows_q[0];
  assign accept   = in_valid && in_ready;
  assign in_ready = !busy;
  assign last     = (cnt == RW'(GRID_ROWS - 1));
  assign is_query = (kind_q == lgg_pkg::KIND_QUERY);
  assign stall    = busy && last && is_query && out_valid && !out_ready;
  assign step     = busy && !stall;
  assign row_hit  = (CMPW'(row_q) == CMPW'(cnt));
  assign col_ok   = ((lgg_pkg::COL_W + 1)'(col_q) < (lgg_pkg::COL_W + 1)'(GRID_COLS));

  // Head holds old row cnt; rows ahead are still old, tail holds new rows.
  assign above = (cnt == '0) ? rows_q[GRID_ROWS-1] : prev_old;
  assign below = last ? first_old : rows_q[1];

  lgg_rule #(
    .GRID_COLS (GRID_COLS)
  ) u_rule (
    .above     (above),
    .mid       (head),
    .below     (below),
    .sel       (col_q[CW-1:0]),
    .next_row  (rule_row),
    .sel_count (rule_count)
  );

  assign set_mask = GRID_COLS'(1) << col_q;

  always_comb begin
    head_new = head;
    case (kind_q)
      lgg_pkg::KIND_ADVANCE: head_new = rule_row;
      lgg_pkg::KIND_SET: begin
        if (row_hit && col_ok) begin
          head_new = alive_q ? (head | set_mask) : (head & ~set_mask);
        end
      end
      default: head_new = head;
    endcase
  end

  always_comb begin
    hit_bits_next  = hit_bits;
    hit_alive_next = hit_alive;
    hit_count_next = hit_count;
    if (is_query && row_hit && col_ok) begin
      hit_bits_next  = lgg_pkg::BITS_W'(head);
      hit_alive_next = head[col_q[CW-1:0]];
      hit_count_next = rule_count;
    end
  end

  for (genvar i = 0; i < GRID_ROWS; i++) begin : g_ring
    logic [GRID_COLS-1:0] d;
    if (i == GRID_ROWS - 1) begin : g_tail
      assign d = head_new;
    end else begin : g_mid
      assign d = rows_q[i+1];
    end
    lgg_cell #(
      .GRID_COLS (GRID_COLS)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (step),
      .d     (d),
      .q     (rows_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (step) begin
        cnt <= last ? '0 : cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
      if (step && last && is_query) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q    <= kind;
      row_q     <= row;
      col_q     <= col;
      alive_q   <= alive;
      first_old <= head;
      hit_bits  <= '0;
      hit_alive <= 1'b0;
      hit_count <= '0;
    end else if (step) begin
      prev_old  <= head;
      hit_bits  <= hit_bits_next;
      hit_alive <= hit_alive_next;
      hit_count <= hit_count_next;
    end
    if (step && last && is_query) begin
      row_bits       <= hit_bits_next;
      cell_alive     <= hit_alive_next;
      neighbor_count <= hit_count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && (cnt == '0))
    else $error("accepted item did not start a revolution");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (cnt == '0))
    else $error("row counter moved while idle");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy) && $past(last) && $past(is_query))
    else $error("result raised outside the end of a query");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (neighbor_count <= lgg_pkg::MAX_COUNT))
    else $error("neighbor count above eight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(row_bits) && $stable(neighbor_count))
    else $error("pending result overwritten");
`endif

endmodule
